/* src/arb_pkg.sv */
package arb_pkg;

  // ring geometry
  localparam int DEPTH    = 64;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int DATA_W   = 16;
  localparam int SIZE_W   = 7;
  localparam int MODE_W   = 3;
  localparam int OP_W     = 2;
  localparam int AGE_W    = 7;
  localparam int STATUS_W = 2;

  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(DEPTH);
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

  // data values
  localparam logic [DATA_W-1:0] EMPTY_SLOT = 16'hFFFF;
  localparam logic [DATA_W-1:0] MAX_VALUE  = 16'd4096;
  localparam logic [DATA_W-1:0] SUM_LIMIT  = 16'd65534;

  // operations
  localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
  localparam logic [OP_W-1:0] OP_GET    = 2'd1;
  localparam logic [OP_W-1:0] OP_SET    = 2'd2;
  localparam logic [OP_W-1:0] OP_UPDATE = 2'd3;

  // result status
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_AGE  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  // merge modes
  localparam logic [MODE_W-1:0] MODE_LAST = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MAX  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MIN  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_AVG  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SUM  = 3'd4;

  // configuration register indexes
  localparam logic REG_SIZE = 1'b0;
  localparam logic REG_MODE = 1'b1;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [AGE_W-1:0]  age;
    logic [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   old_value;
    logic [DATA_W-1:0]   new_value;
  } rsp_t;

endpackage

/* src/aggregating_ring_buffer.sv */
// A command taken is registered into s_live and then into done and its result.
// Throughput: one command per cycle unless busy; the slot read, merge and
// write-back run as a two-stage read-modify-write on one RAM with forwarding
// between neighbors. Reset (rst, synchronous) and any configuration beat
// clear every slot to empty at once through per-slot valid bits; results
// cannot be stalled by the receiver.
module aggregating_ring_buffer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  arb_pkg::req_t              request,
  output logic                       done,
  output arb_pkg::rsp_t              result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [arb_pkg::SIZE_W-1:0] cfg_data
);

  // configuration and ring control
  logic [arb_pkg::SIZE_W-1:0] size_in_use;
  logic [arb_pkg::MODE_W-1:0] merge_mode;
  logic [arb_pkg::SIZE_W-1:0] head;
  logic [arb_pkg::SIZE_W-1:0] head_next;
  logic [arb_pkg::DEPTH-1:0]  slot_valid;
  logic                       cfg_write;

  // first stage, combinational from the command
  logic                         accept;
  logic [arb_pkg::SIZE_W-1:0]   eff_size;
  logic [arb_pkg::SIZE_W-1:0]   head_inc;
  logic [arb_pkg::ADDR_W-1:0]   push_idx;
  logic [arb_pkg::SIZE_W:0]     age_pos;
  logic [arb_pkg::ADDR_W-1:0]   age_idx;
  logic                         age_ok;
  logic                         val_over;
  logic [arb_pkg::STATUS_W-1:0] status_in;
  logic [arb_pkg::ADDR_W-1:0]   rd_addr;

  // second stage registers
  logic                         s_live;
  logic [arb_pkg::OP_W-1:0]     s_op;
  logic [arb_pkg::ADDR_W-1:0]   s_idx;
  logic [arb_pkg::DATA_W-1:0]   s_val;
  logic [arb_pkg::STATUS_W-1:0] s_status;
  logic                         s_valid;
  logic                         fwd_hit;
  logic [arb_pkg::DATA_W-1:0]   fwd_data;

  // second stage logic
  logic [arb_pkg::DATA_W-1:0] ram_q;
  logic [arb_pkg::DATA_W-1:0] old_slot;
  logic [arb_pkg::DATA_W-1:0] merged;
  logic [arb_pkg::DATA_W-1:0] new_slot;
  logic                       wr_en;
  arb_pkg::rsp_t              result_next;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // busy is rst registered; commands are refused while it is high
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  // effective ring size: zero acts as one, capped at the store depth
  always_comb begin
    if (size_in_use == '0) begin
      eff_size = arb_pkg::SIZE_W'(1);
    end else if (size_in_use > arb_pkg::SIZE_MAX) begin
      eff_size = arb_pkg::SIZE_MAX;
    end else begin
      eff_size = size_in_use;
    end
  end

  // push slot: head advances and wraps back to one
  assign head_inc = head + arb_pkg::SIZE_W'(1);
  always_comb begin
    head_next = (head_inc > eff_size) ? arb_pkg::SIZE_W'(1) : head_inc;
  end
  assign push_idx = arb_pkg::ADDR_W'(head_next - arb_pkg::SIZE_W'(1));

  // slot of an age, counting back from the head with wrap
  always_comb begin
    if (request.age > head) begin
      age_pos = {1'b0, eff_size} + {1'b0, head} - {1'b0, request.age};
    end else begin
      age_pos = {1'b0, head} - {1'b0, request.age};
    end
    age_idx = (age_pos >= (arb_pkg::SIZE_W+1)'(arb_pkg::DEPTH)) ? '0
                                                                : arb_pkg::ADDR_W'(age_pos);
  end

  assign age_ok   = (request.age != '0) && (request.age <= eff_size);
  assign val_over = (request.value > arb_pkg::MAX_VALUE) && (request.value != arb_pkg::EMPTY_SLOT);

  // status decode; set checks age first, update checks value first
  always_comb begin
    status_in = arb_pkg::STATUS_OK;
    unique case (request.operation)
      arb_pkg::OP_PUSH: begin
        if (val_over) status_in = arb_pkg::STATUS_OVERFLOW;
      end
      arb_pkg::OP_GET: begin
        if (!age_ok) status_in = arb_pkg::STATUS_BAD_AGE;
      end
      arb_pkg::OP_SET: begin
        if (!age_ok) status_in = arb_pkg::STATUS_BAD_AGE;
        else if (val_over) status_in = arb_pkg::STATUS_OVERFLOW;
      end
      arb_pkg::OP_UPDATE: begin
        if (val_over) status_in = arb_pkg::STATUS_OVERFLOW;
        else if (!age_ok) status_in = arb_pkg::STATUS_BAD_AGE;
      end
      default: status_in = arb_pkg::STATUS_OK;
    endcase
  end

  assign rd_addr = (request.operation == arb_pkg::OP_PUSH) ? push_idx : age_idx;

  // configuration registers, head and slot valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= arb_pkg::SIZE_RESET;
      merge_mode  <= arb_pkg::MODE_LAST;
      head        <= '0;
      slot_valid  <= '0;
    end else if (cfg_write) begin
      if (cfg_index == arb_pkg::REG_SIZE) begin
        size_in_use <= cfg_data;
      end else begin
        merge_mode <= cfg_data[arb_pkg::MODE_W-1:0];
      end
      head       <= '0;
      slot_valid <= '0;
    end else begin
      if (accept && request.operation == arb_pkg::OP_PUSH && status_in == arb_pkg::STATUS_OK) begin
        head <= head_next;
      end
      if (wr_en) begin
        slot_valid[s_idx] <= 1'b1;
      end
    end
  end

  // slot store
  arb_ram #(
    .WIDTH(arb_pkg::DATA_W),
    .DEPTH(arb_pkg::DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s_idx),
    .wr_data (new_slot),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // stage register; forward a write-back landing on the slot being read
  always_ff @(posedge clk) begin
    if (rst) begin
      s_live <= 1'b0;
    end else begin
      s_live <= accept;
    end
    if (accept) begin
      s_op     <= request.operation;
      s_idx    <= rd_addr;
      s_val    <= request.value;
      s_status <= status_in;
      s_valid  <= slot_valid[rd_addr];
      fwd_hit  <= wr_en && (s_idx == rd_addr);
      fwd_data <= new_slot;
    end
  end

  always_comb begin
    if (fwd_hit) begin
      old_slot = fwd_data;
    end else if (s_valid) begin
      old_slot = ram_q;
    end else begin
      old_slot = arb_pkg::EMPTY_SLOT;
    end
  end

  arb_merge u_merge (
    .mode      (merge_mode),
    .old_value (old_slot),
    .value     (s_val),
    .merged    (merged)
  );

  always_comb begin
    case (s_op)
      arb_pkg::OP_GET:    new_slot = old_slot;
      arb_pkg::OP_UPDATE: new_slot = merged;
      default:            new_slot = s_val;
    endcase
  end

  assign wr_en = s_live && (s_status == arb_pkg::STATUS_OK) && (s_op != arb_pkg::OP_GET);

  // errors report zero contents
  always_comb begin
    result_next.status = s_status;
    if (s_status == arb_pkg::STATUS_OK) begin
      result_next.old_value = old_slot;
      result_next.new_value = new_slot;
    end else begin
      result_next.old_value = '0;
      result_next.new_value = '0;
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s_live;
    end
    if (s_live) begin
      result <= result_next;
    end
  end

`ifndef SYNTH
  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 2))
    else $error("result beat without a command two cycles earlier");

  a_head_in_ring: assert property (@(posedge clk) disable iff (rst)
    head <= eff_size)
    else $error("head beyond the ring size");

  a_no_write_on_error: assert property (@(posedge clk) disable iff (rst)
    (s_live && s_status != arb_pkg::STATUS_OK) |-> !wr_en)
    else $error("slot written by a failed command");

  a_push_moves_head: assert property (@(posedge clk) disable iff (rst)
    (accept && !cfg_write && request.operation == arb_pkg::OP_PUSH
     && status_in == arb_pkg::STATUS_OK) |=> (head != '0))
    else $error("push left the head at zero");
`endif

endmodule

/* src/arb_ram.sv */
module arb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/arb_merge.sv */
module arb_merge (
  input  logic [arb_pkg::MODE_W-1:0] mode,
  input  logic [arb_pkg::DATA_W-1:0] old_value,
  input  logic [arb_pkg::DATA_W-1:0] value,
  output logic [arb_pkg::DATA_W-1:0] merged
);

  logic [arb_pkg::DATA_W:0] sum;

  assign sum = {1'b0, old_value} + {1'b0, value};

  // an empty operand yields the new value; unused modes behave as last
  always_comb begin
    merged = value;
    if (old_value != arb_pkg::EMPTY_SLOT && value != arb_pkg::EMPTY_SLOT) begin
      case (mode)
        arb_pkg::MODE_MAX: merged = (value > old_value) ? value : old_value;
        arb_pkg::MODE_MIN: merged = (value < old_value) ? value : old_value;
        arb_pkg::MODE_AVG: merged = sum[arb_pkg::DATA_W:1];
        arb_pkg::MODE_SUM: begin
          merged = (sum <= {1'b0, arb_pkg::SUM_LIMIT}) ? sum[arb_pkg::DATA_W-1:0] : old_value;
        end
        default: merged = value;
      endcase
    end
  end

endmodule

/* test/aggregating_ring_buffer_tb.sv */
`timescale 1ns / 1ps

module aggregating_ring_buffer_tb;
  import arb_pkg::*;

  localparam int PHASES       = 16;
  localparam int PHASE_ITEMS  = 120;
  localparam int QUIET_LIMIT  = 2000;
  localparam int REPORT_LIMIT = 100;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              start     = 1'b0;
  logic              busy;
  req_t              request   = '0;
  logic              done;
  rsp_t              result;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_index = REG_SIZE;
  logic [SIZE_W-1:0] cfg_data  = '0;

  // shadow of the ring, updated as beats are accepted
  logic [DATA_W-1:0] ring_slot [DEPTH];
  int unsigned       ring_head;
  logic [SIZE_W-1:0] ring_size_reg;
  logic [MODE_W-1:0] ring_mode_reg;

  rsp_t        results_due [$];
  int unsigned errors       = 0;
  int unsigned quiet_cycles = 0;
  bit          gaps_on      = 1'b1;

  aggregating_ring_buffer DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // ring behavior
  // ---------------------------------------------------------------------------

  // size 0 behaves as 1, sizes past the ring behave as the full ring
  function automatic int unsigned ring_span();
    int unsigned s;
    s = ring_size_reg;
    if (s == 0) s = 1;
    if (s > DEPTH) s = DEPTH;
    return s;
  endfunction

  function automatic void ring_clear();
    for (int k = 0; k < DEPTH; k++) ring_slot[ADDR_W'(k)] = EMPTY_SLOT;
    ring_head = 0;
  endfunction

  function automatic bit over_limit(logic [DATA_W-1:0] v);
    return v > MAX_VALUE && v != EMPTY_SLOT;
  endfunction

  function automatic bit age_fits(int unsigned age);
    return age != 0 && age <= ring_span();
  endfunction

  // age 1 is the newest push; older ages wrap back around the span
  function automatic int unsigned age_slot(int unsigned age);
    int unsigned idx;
    if (age > ring_head) idx = ring_span() + ring_head - age;
    else idx = ring_head - age;
    if (idx >= DEPTH) idx = 0;
    return idx;
  endfunction

  function automatic logic [DATA_W-1:0] merged(logic [DATA_W-1:0] old, logic [DATA_W-1:0] v);
    int unsigned total;
    total = old;
    total += v;
    // an empty operand always just overwrites
    if (old == EMPTY_SLOT || v == EMPTY_SLOT) return v;
    case (ring_mode_reg)
      MODE_MAX: return (v > old) ? v : old;
      MODE_MIN: return (v < old) ? v : old;
      MODE_AVG: return DATA_W'(total >> 1);
      MODE_SUM: return (total <= SUM_LIMIT) ? DATA_W'(total) : old;
      default:  return v;
    endcase
  endfunction

  // applies one command to the shadow ring and returns its result beat
  function automatic rsp_t ring_apply(req_t r);
    rsp_t        res;
    int unsigned idx;
    int unsigned age;
    res = '0;
    res.status = STATUS_OK;
    age = r.age;
    case (r.operation)
      OP_PUSH: begin
        if (over_limit(r.value)) begin
          res.status = STATUS_OVERFLOW;
        end else begin
          ring_head++;
          if (ring_head >= ring_span() + 1) ring_head = 1;
          idx = ring_head - 1;
          res.old_value = ring_slot[ADDR_W'(idx)];
          ring_slot[ADDR_W'(idx)] = r.value;
          res.new_value = r.value;
        end
      end
      OP_GET: begin
        if (!age_fits(age)) begin
          res.status = STATUS_BAD_AGE;
        end else begin
          res.old_value = ring_slot[ADDR_W'(age_slot(age))];
          res.new_value = res.old_value;
        end
      end
      OP_SET: begin
        // set checks the age before the value
        if (!age_fits(age)) begin
          res.status = STATUS_BAD_AGE;
        end else if (over_limit(r.value)) begin
          res.status = STATUS_OVERFLOW;
        end else begin
          idx = age_slot(age);
          res.old_value = ring_slot[ADDR_W'(idx)];
          ring_slot[ADDR_W'(idx)] = r.value;
          res.new_value = r.value;
        end
      end
      default: begin
        // update checks the value before the age
        if (over_limit(r.value)) begin
          res.status = STATUS_OVERFLOW;
        end else if (!age_fits(age)) begin
          res.status = STATUS_BAD_AGE;
        end else begin
          idx = age_slot(age);
          res.old_value = ring_slot[ADDR_W'(idx)];
          res.new_value = merged(res.old_value, r.value);
          ring_slot[ADDR_W'(idx)] = res.new_value;
        end
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // monitor and scoreboard
  // ---------------------------------------------------------------------------

  task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= REPORT_LIMIT) $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    rsp_t due;
    if (!rst) begin
      if (done) begin
        if (results_due.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $error("result beat with nothing pending: status %0d", result.status);
        end else begin
          due = results_due.pop_front();
          check_field("status", DATA_W'(due.status), DATA_W'(result.status));
          check_field("old_value", due.old_value, result.old_value);
          check_field("new_value", due.new_value, result.new_value);
        end
      end
      if (start && !busy) results_due.push_back(ring_apply(request));
      // any register write empties the ring
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SIZE) ring_size_reg = cfg_data;
        else ring_mode_reg = cfg_data[MODE_W-1:0];
        ring_clear();
      end
    end
  end

  // stall watchdog: counts cycles with no beat on any channel
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("aggregating_ring_buffer: mismatch");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  task automatic issue(logic [OP_W-1:0] op, int unsigned age, int unsigned value);
    req_t r;
    r.operation = op;
    r.age       = AGE_W'(age);
    r.value     = DATA_W'(value);
    if (gaps_on) begin
      while ($urandom_range(99) < 32) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start   <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
  endtask

  // hold off commands until every pending result has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_reg(logic idx, logic [SIZE_W-1:0] data);
    drain();
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset config: full ring, last-write mode
  task automatic test_edge_cases();
    issue(OP_GET, 1, 0);              // newest slot while nothing pushed yet
    issue(OP_PUSH, 0, 0);
    issue(OP_PUSH, 0, MAX_VALUE);
    issue(OP_PUSH, 0, EMPTY_SLOT);
    issue(OP_PUSH, 0, MAX_VALUE + 1); // overflow
    issue(OP_PUSH, 0, SUM_LIMIT);     // overflow
    issue(OP_GET, 1, 0);
    issue(OP_GET, 3, 0);
    issue(OP_GET, 0, 0);              // bad age
    issue(OP_GET, DEPTH, 0);
    issue(OP_GET, DEPTH + 1, 0);      // bad age
    issue(OP_GET, 127, 0);            // bad age
    issue(OP_SET, 0, 5000);           // both bad, set reports the age
    issue(OP_UPDATE, 0, 5000);        // both bad, update reports the value
    issue(OP_SET, 2, 1234);
    issue(OP_UPDATE, 2, 77);
    issue(OP_SET, 1, EMPTY_SLOT);
  endtask

  // max, min, average and sum merge rules, with an empty value and an empty slot
  task automatic test_merge_rules();
    for (int m = MODE_MAX; m <= MODE_SUM; m++) begin
      set_reg(REG_MODE, SIZE_W'(m));
      issue(OP_PUSH, 0, 1000);
      issue(OP_UPDATE, 1, 2000);
      issue(OP_UPDATE, 1, EMPTY_SLOT);
      issue(OP_UPDATE, 1, 5);
    end
  endtask

  task automatic random_item(bit accumulate);
    int unsigned span;
    int unsigned pick;
    logic [OP_W-1:0] op;
    int unsigned age;
    int unsigned value;
    span = ring_span();
    pick = $urandom_range(99);
    if (accumulate) op = (pick < 85) ? OP_UPDATE : OP_GET;
    else if (pick < 30) op = OP_PUSH;
    else if (pick < 50) op = OP_GET;
    else if (pick < 70) op = OP_SET;
    else op = OP_UPDATE;

    pick = $urandom_range(99);
    if (pick < 88) age = $urandom_range(span, 1);
    else if (pick < 94) age = 0;
    else age = $urandom_range(127, span + 1);

    pick = $urandom_range(99);
    if (accumulate) value = $urandom_range(MAX_VALUE, 3000);
    else if (pick < 80) value = $urandom_range(MAX_VALUE, 0);
    else if (pick < 88) value = EMPTY_SLOT;
    else if (pick < 94) value = $urandom_range(SUM_LIMIT, MAX_VALUE + 1);
    else begin
      case ($urandom_range(3))
        0:       value = 0;
        1:       value = MAX_VALUE;
        2:       value = MAX_VALUE + 1;
        default: value = SUM_LIMIT;
      endcase
    end
    issue(op, age, value);
  endtask

  task automatic test_random_traffic();
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] mode_word;
    bit accumulate;
    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(7))
        0:       size = 0;
        1:       size = 1;
        2:       size = 2;
        3:       size = 127;
        4:       size = SIZE_W'(DEPTH);
        5:       size = SIZE_W'($urandom_range(8, 3));
        default: size = SIZE_W'($urandom_range(DEPTH, 1));
      endcase
      // upper bits of the mode word are don't-care
      mode_word = {(SIZE_W-MODE_W)'($urandom_range(15)), MODE_W'($urandom_range(7))};
      // one phase piles sums onto a single slot until it saturates
      accumulate = (p == 5);
      if (accumulate) begin
        size = 1;
        mode_word = SIZE_W'(MODE_SUM);
      end
      if ($urandom_range(1)) begin
        set_reg(REG_SIZE, size);
        set_reg(REG_MODE, mode_word);
      end else begin
        set_reg(REG_MODE, mode_word);
        set_reg(REG_SIZE, size);
      end
      gaps_on = (p != 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 8 && i == PHASE_ITEMS / 2) drain();
        random_item(accumulate);
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    ring_size_reg = SIZE_RESET;
    ring_mode_reg = MODE_LAST;
    ring_clear();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_edge_cases();
    test_merge_rules();
    test_random_traffic();

    drain();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("aggregating_ring_buffer: match");
    end else begin
      $display("aggregating_ring_buffer: mismatch");
    end
    $finish;
  end

endmodule
